>>> design/mbe_pkg.sv
// mbe_pkg: shared types and constants for the escape-time iteration block
// no dependencies; used by the channel interfaces, the top-level design module and the testbench

package mbe_pkg;

	localparam int IN_W    = 31;
	localparam int COUNT_W = 8;
	localparam int MAG_W   = 35;

	localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 8'd42;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_RR,
		ST_MUL_II,
		ST_MUL_RI,
		ST_CHECK
	} state_t;

endpackage

>>> design/mbe_point_if.sv
// mbe_point_if: valid/ready channel carrying one point c
// depends on mbe_pkg for field widths

interface mbe_point_if;
	logic                             valid;
	logic                             ready;
	logic signed [mbe_pkg::IN_W-1:0] c_real;
	logic signed [mbe_pkg::IN_W-1:0] c_imag;

	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

>>> design/mbe_result_if.sv
// mbe_result_if: valid/ready channel carrying one escape-time result
// depends on mbe_pkg for field widths

interface mbe_result_if;
	logic                         valid;
	logic                         ready;
	logic [mbe_pkg::COUNT_W-1:0] escape_count;
	logic                         inside_set;
	logic [mbe_pkg::MAG_W-1:0]   magnitude_sq;

	modport source (output valid, output escape_count, output inside_set,
		output magnitude_sq, input ready);
	modport sink (input valid, input escape_count, input inside_set,
		input magnitude_sq, output ready);
endinterface

>>> design/mbe_cfg_if.sv
// mbe_cfg_if: valid/ready write channel for the iteration limit register
// depends on mbe_pkg for the register width

interface mbe_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mbe_pkg::COUNT_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/mandelbrot_escape_iteration.sv
// mandelbrot_escape_iteration: escape-time orbit of one point c per word
// depends on mbe_pkg, mbe_point_if, mbe_result_if, mbe_cfg_if and mbe_mul
//
//   channel   dir   word
//   point     in    c_real, c_imag (signed fixed point)
//   result    out   escape_count, inside_set, magnitude_sq
//   cfg       in    max_iter
//
// a point is taken in idle; each test of |z|^2 then runs the states mul_rr, mul_ii,
// mul_ri and check: the single multiplier forms zr*zr, zi*zi and zr*zi in turn, then
// the check state adds, compares and updates z unless the point escapes.
// reset sets max_iter to 42 and empties the block; no clearing pass.
// the result sits in an output register; a full, unread result holds the
// sequencer in its check state, and point.ready is high only when idle.

module mandelbrot_escape_iteration #(
	parameter int FRAC_BITS = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	mbe_cfg_if.sink             cfg,
	mbe_point_if.sink           point,
	mbe_result_if.source        result
);

	localparam int ZW = (FRAC_BITS + 5 > 33) ? FRAC_BITS + 5 : 33;
	localparam int PW = 2 * ZW;
	localparam int SW = 2 * ZW - FRAC_BITS;
	localparam int MW = (SW + 1 > 36) ? SW + 1 : 36;
	localparam int EW = ZW - mbe_pkg::IN_W;

	localparam logic [MW-1:0] FOUR    = {{(MW-1){1'b0}}, 1'b1} << (FRAC_BITS + 2);
	localparam logic [MW-1:0] MAG_MAX = {{(MW-mbe_pkg::MAG_W){1'b0}},
		{mbe_pkg::MAG_W{1'b1}}};

	mbe_pkg::state_t state_q, state_d;

	logic [mbe_pkg::COUNT_W-1:0] max_iter_q;
	logic [mbe_pkg::COUNT_W-1:0] count_q;
	logic signed [ZW-1:0]        zr_q, zi_q;
	logic signed [mbe_pkg::IN_W-1:0] cr_q, ci_q;
	logic [SW-1:0]               zr2_q, zi2_q;

	logic                        out_valid_q;
	logic [mbe_pkg::COUNT_W-1:0] out_count_q;
	logic                        out_inside_q;
	logic [mbe_pkg::MAG_W-1:0]   out_mag_q;

	logic signed [ZW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] product_s1;
	logic signed [PW-1:0] square_shr, cross_shr;
	logic [MW-1:0]        mag;
	logic                 escape;
	logic                 take_point;
	logic                 load_result;
	logic                 step;
	logic signed [ZW-1:0] zr_next, zi_next;

	mbe_mul #(.W(ZW)) u_mul (
		.clk        (clk),
		.a          (mul_a),
		.b          (mul_b),
		.product_s1 (product_s1)
	);

	assign mul_a = (state_q == mbe_pkg::ST_MUL_II) ? zi_q : zr_q;
	assign mul_b = (state_q == mbe_pkg::ST_MUL_RR) ? zr_q : zi_q;

	assign square_shr = product_s1 >>> FRAC_BITS;
	assign cross_shr  = product_s1 >>> (FRAC_BITS - 1);

	assign mag    = {{(MW-SW){1'b0}}, zr2_q} + {{(MW-SW){1'b0}}, zi2_q};
	assign escape = (mag > FOUR) || (count_q >= max_iter_q);

	assign zr_next = zr2_q[ZW-1:0] - zi2_q[ZW-1:0] + {{EW{cr_q[mbe_pkg::IN_W-1]}}, cr_q};
	assign zi_next = cross_shr[ZW-1:0] + {{EW{ci_q[mbe_pkg::IN_W-1]}}, ci_q};

	assign cfg.ready   = 1'b1;
	assign point.ready = (state_q == mbe_pkg::ST_IDLE);

	assign result.valid        = out_valid_q;
	assign result.escape_count = out_count_q;
	assign result.inside_set   = out_inside_q;
	assign result.magnitude_sq = out_mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		take_point  = 1'b0;
		load_result = 1'b0;
		step        = 1'b0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (point.valid) begin
					take_point = 1'b1;
					state_d    = mbe_pkg::ST_MUL_RR;
				end
			end
			mbe_pkg::ST_MUL_RR: state_d = mbe_pkg::ST_MUL_II;
			mbe_pkg::ST_MUL_II: state_d = mbe_pkg::ST_MUL_RI;
			mbe_pkg::ST_MUL_RI: state_d = mbe_pkg::ST_CHECK;
			mbe_pkg::ST_CHECK: begin
				if (!escape) begin
					step    = 1'b1;
					state_d = mbe_pkg::ST_MUL_RR;
				end else if (!out_valid_q || result.ready) begin
					load_result = 1'b1;
					state_d     = mbe_pkg::ST_IDLE;
				end
			end
			default: state_d = mbe_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= mbe_pkg::MAX_ITER_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				max_iter_q <= cfg.data;
			end
			if (take_point) begin
				count_q <= '0;
			end else if (step) begin
				count_q <= count_q + 1'b1;
			end
			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// orbit and result datapath
	always_ff @(posedge clk) begin
		if (take_point) begin
			zr_q <= '0;
			zi_q <= '0;
			cr_q <= point.c_real;
			ci_q <= point.c_imag;
		end else if (step) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
		end
		if (state_q == mbe_pkg::ST_MUL_II) begin
			zr2_q <= square_shr[SW-1:0];
		end
		if (state_q == mbe_pkg::ST_MUL_RI) begin
			zi2_q <= square_shr[SW-1:0];
		end
		if (load_result) begin
			out_count_q  <= count_q;
			out_inside_q <= (count_q == max_iter_q);
			out_mag_q    <= (mag > MAG_MAX) ? {mbe_pkg::MAG_W{1'b1}} : mag[mbe_pkg::MAG_W-1:0];
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mbe_pkg::ST_IDLE) |-> (count_q <= max_iter_q))
		else $error("step count passed the iteration limit");

	a_inside_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_result |=> (result.inside_set == (result.escape_count == max_iter_q)))
		else $error("inside flag disagrees with step count");

	a_square_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mbe_pkg::ST_MUL_II) |-> ($past(state_q) == mbe_pkg::ST_MUL_RR))
		else $error("multiplier sequence out of order");

	a_step_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (state_q == mbe_pkg::ST_MUL_RR) && (count_q != '0))
		else $error("orbit step did not restart the multiply sequence");
`endif

endmodule

>>> design/mbe_mul.sv
// mbe_mul: shared signed multiplier with a registered product
// no package dependencies; instantiated by mandelbrot_escape_iteration

module mbe_mul #(
	parameter int W = 33
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] product_s1
);

	always_ff @(posedge clk) begin
		product_s1 <= a * b;
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: randomized valid/ready test of mandelbrot_escape_iteration against an orbit predictor
// depends on mbe_pkg, mbe_point_if, mbe_result_if, mbe_cfg_if and the design top level

module testbench;

	localparam int     IN_W         = mbe_pkg::IN_W;
	localparam int     COUNT_W      = mbe_pkg::COUNT_W;
	localparam int     MAG_W        = mbe_pkg::MAG_W;
	localparam int     FRAC         = 28;
	localparam int     ONE          = 1 << FRAC;
	localparam int     IN_MAX       = (1 << (IN_W - 1)) - 1;
	localparam int     IN_MIN       = -(1 << (IN_W - 1));
	localparam longint ESC_BOUND    = longint'(4) << FRAC;
	localparam longint MAG_TOP      = (longint'(1) << MAG_W) - 1;
	localparam int     DRAIN_CYCLES = 1100;
	localparam int     TIMEOUT_NS   = 40_000_000;
	localparam int     REPORT_CAP   = 40;

	typedef struct packed {
		logic signed [IN_W-1:0] re;
		logic signed [IN_W-1:0] im;
		logic                   drain;
	} point_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               in_set;
		logic [MAG_W-1:0]   mag;
	} orbit_result_t;

	logic clk = 1'b0;
	logic arst_n;

	mbe_cfg_if    cfg_ch ();
	mbe_point_if  point_ch ();
	mbe_result_if result_ch ();

	mandelbrot_escape_iteration #(.FRAC_BITS(FRAC)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.point  (point_ch),
		.result (result_ch)
	);

	point_item_t        pending_points[$];
	orbit_result_t      orbit_due[$];
	logic [COUNT_W-1:0] iter_limit = mbe_pkg::MAX_ITER_RESET;
	int                 mismatches = 0;
	int                 src_gap    = 0;
	int                 sink_gap   = 0;
	bit                 src_idle   = 1'b1;
	bit                 sink_idle  = 1'b1;

	always #6 clk = ~clk;

	function automatic orbit_result_t escape_orbit(input logic signed [IN_W-1:0] c_re,
			input logic signed [IN_W-1:0] c_im, input logic [COUNT_W-1:0] limit);
		longint        zr, zi, zr2, zi2, next_re, mag;
		int            steps;
		orbit_result_t r;
		zr = 0;
		zi = 0;
		steps = 0;
		while (1) begin
			zr2 = (zr * zr) >>> FRAC;
			zi2 = (zi * zi) >>> FRAC;
			mag = zr2 + zi2;
			if (mag > ESC_BOUND || steps >= limit)
				break;
			next_re = zr2 - zi2 + c_re;
			zi = ((zr * zi) >>> (FRAC - 1)) + c_im;
			zr = next_re;
			steps++;
		end
		r.count  = COUNT_W'(steps);
		r.in_set = (steps == limit);
		r.mag    = (mag > MAG_TOP) ? MAG_W'(MAG_TOP) : MAG_W'(mag);
		return r;
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [IN_W-1:0] pick(input real lo, input real hi);
		int l, h;
		l = int'(lo * ONE);
		h = int'(hi * ONE);
		return IN_W'(l + int'($urandom_range(0, h - l)));
	endfunction

	function automatic point_item_t random_point();
		point_item_t p;
		int          r;
		r = $urandom_range(0, 99);
		p.drain = 1'b0;
		if (r < 60) begin
			p.re = pick(-2.1, 0.6);
			p.im = pick(-1.3, 1.3);
		end else if (r < 70) begin
			p.re = pick(-0.8, -0.7);
			p.im = pick(-0.15, 0.15);
		end else if (r < 78) begin
			p.re = pick(0.2, 0.3);
			p.im = pick(-0.05, 0.05);
		end else if (r < 84) begin
			p.re = pick(-2.05, -1.95);
			p.im = pick(-0.02, 0.02);
		end else begin
			p.re = IN_W'($urandom());
			p.im = IN_W'($urandom());
		end
		return p;
	endfunction

	task automatic report(input string msg);
		if (mismatches < REPORT_CAP)
			$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic queue_point(input int re, input int im);
		point_item_t p;
		p.re = IN_W'(re);
		p.im = IN_W'(im);
		p.drain = 1'b0;
		pending_points.push_back(p);
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] lim);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= lim;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		iter_limit = lim;
	endtask

	// checked away from the rising edge so driver and monitor updates have settled
	task automatic wait_idle();
		while (pending_points.size() != 0 || orbit_due.size() != 0 || point_ch.valid)
			@(negedge clk);
	endtask

	// point driver
	always @(posedge clk or negedge arst_n) begin
		point_item_t nxt;
		if (!arst_n) begin
			point_ch.valid <= 1'b0;
		end else begin
			if (point_ch.valid && point_ch.ready) begin
				orbit_due.push_back(escape_orbit(point_ch.c_real, point_ch.c_imag,
					iter_limit));
				src_gap = src_idle ? pause_len() : 0;
			end
			if (!(point_ch.valid && !point_ch.ready)) begin
				if (src_gap > 0) begin
					src_gap--;
					point_ch.valid <= 1'b0;
				end else if (pending_points.size() != 0 &&
						(!pending_points[0].drain || orbit_due.size() == 0)) begin
					nxt = pending_points.pop_front();
					point_ch.valid  <= 1'b1;
					point_ch.c_real <= nxt.re;
					point_ch.c_imag <= nxt.im;
				end else begin
					point_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		orbit_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (orbit_due.size() == 0) begin
					report($sformatf("result word with none pending: count %0d mag %0d",
						result_ch.escape_count, result_ch.magnitude_sq));
				end else begin
					want = orbit_due.pop_front();
					if (result_ch.escape_count !== want.count)
						report($sformatf("escape_count got %0d expected %0d",
							result_ch.escape_count, want.count));
					if (result_ch.inside_set !== want.in_set)
						report($sformatf("inside_set got %0b expected %0b",
							result_ch.inside_set, want.in_set));
					if (result_ch.magnitude_sq !== want.mag)
						report($sformatf("magnitude_sq got %0d expected %0d",
							result_ch.magnitude_sq, want.mag));
				end
				sink_gap = sink_idle ? pause_len() : 0;
			end
			if (sink_gap > 0) begin
				sink_gap--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("mandelbrot_escape_iteration: mismatch");
		$finish;
	end

	initial begin
		logic [COUNT_W-1:0] phase_limit [7];
		int                 phase_items [7];
		point_item_t        p;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		point_ch.valid = 1'b0;
		point_ch.c_real = '0;
		point_ch.c_imag = '0;
		result_ch.ready = 1'b0;
		phase_limit = '{8'd255, 8'd1, 8'd0, COUNT_W'($urandom_range(2, 254)), 8'd255,
			COUNT_W'($urandom_range(2, 254)), COUNT_W'($urandom_range(2, 254))};
		phase_items = '{110, 40, 30, 110, 110, 110, 90};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed points at the reset limit
		queue_point(0, 0);
		queue_point(IN_MAX, IN_MAX);
		queue_point(IN_MIN, IN_MIN);
		queue_point(IN_MAX, IN_MIN);
		queue_point(IN_MIN, IN_MAX);
		queue_point(IN_MAX, 0);
		queue_point(0, IN_MIN);
		queue_point(-2 * ONE, 0);
		queue_point(-2 * ONE - 1, 0);
		queue_point(2 * ONE, 0);
		queue_point(ONE / 4, 0);
		queue_point(ONE / 4 + 1, 0);
		queue_point(-ONE, 0);
		queue_point(0, ONE);
		queue_point(0, -ONE);
		queue_point(-3 * (ONE / 4), ONE / 10);
		queue_point(-2 * ONE, ONE / 1024);
		queue_point(-1, -1);
		queue_point(1, 1);
		queue_point(int'(31'h2AAAAAAA), int'(31'h55555555));
		queue_point(-int'(0.3 * ONE), int'(0.6 * ONE));
		wait_idle();

		foreach (phase_limit[ph]) begin
			write_limit(phase_limit[ph]);
			src_idle  = (ph != 3);
			sink_idle = (ph != 3);
			for (int k = 0; k < phase_items[ph]; k++) begin
				p = random_point();
				// hold off now and then until all results are back
				p.drain = ($urandom_range(0, 49) == 0) || (ph == 0 && k == 5);
				pending_points.push_back(p);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("mandelbrot_escape_iteration: match");
		else
			$display("mandelbrot_escape_iteration: mismatch");
		$finish;
	end

endmodule
